// File: hw/rtl/tgcr_pkg.sv
// ============================================================================
// tgcr_pkg: shared types and constants for the text glyph cell renderer
// Word formats, request action codes, character codes and the 5x7 font ROM.
// ============================================================================
`default_nettype none

package tgcr_pkg;

    // Request actions
    typedef enum logic [1:0] {
        ACT_CHAR     = 2'd0,
        ACT_UNSIGNED = 2'd1,
        ACT_SIGNED   = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    // Number conversion sizes
    localparam int BIN_BITS   = 64;
    localparam int DEC_DIGITS = 20;
    localparam int BCD_BITS   = DEC_DIGITS * 4;

    // Character codes used by the sequencer
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // Request word
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  column;
        logic [7:0]  row;
        logic [7:0]  character;
        logic [63:0] value;
    } req_word_t;

    // Result word: one drawn cell
    typedef struct packed {
        logic [9:0]  cell_offset;
        logic [39:0] glyph_columns;
        logic        last;
    } rsp_word_t;

    // Pack five column bytes, first column in the low byte
    function automatic logic [39:0] glyph_pack(input logic [7:0] c0, input logic [7:0] c1,
                                               input logic [7:0] c2, input logic [7:0] c3,
                                               input logic [7:0] c4);
        glyph_pack = {c4, c3, c2, c1, c0};
    endfunction

    // 5x7 font ROM; codes not in the ROM draw as '?'
    function automatic logic [39:0] glyph_lookup(input logic [7:0] code);
        logic [39:0] g;
        unique case (code)
            8'h20: g = glyph_pack(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            8'h25: g = glyph_pack(8'h63, 8'h13, 8'h08, 8'h64, 8'h63);
            8'h2B: g = glyph_pack(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
            8'h2D: g = glyph_pack(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
            8'h2E: g = glyph_pack(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
            8'h2F: g = glyph_pack(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
            8'h30: g = glyph_pack(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
            8'h31: g = glyph_pack(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
            8'h32: g = glyph_pack(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
            8'h33: g = glyph_pack(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
            8'h34: g = glyph_pack(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
            8'h35: g = glyph_pack(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
            8'h36: g = glyph_pack(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
            8'h37: g = glyph_pack(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
            8'h38: g = glyph_pack(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h39: g = glyph_pack(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
            8'h3A: g = glyph_pack(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
            8'h3D: g = glyph_pack(8'h14, 8'h14, 8'h14, 8'h14, 8'h14);
            8'h41: g = glyph_pack(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
            8'h42: g = glyph_pack(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h43: g = glyph_pack(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            8'h44: g = glyph_pack(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
            8'h45: g = glyph_pack(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            8'h46: g = glyph_pack(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            8'h47: g = glyph_pack(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
            8'h48: g = glyph_pack(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            8'h49: g = glyph_pack(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
            8'h4A: g = glyph_pack(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
            8'h4B: g = glyph_pack(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            8'h4C: g = glyph_pack(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            8'h4D: g = glyph_pack(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
            8'h4E: g = glyph_pack(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
            8'h4F: g = glyph_pack(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h50: g = glyph_pack(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            8'h51: g = glyph_pack(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
            8'h52: g = glyph_pack(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            8'h53: g = glyph_pack(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
            8'h54: g = glyph_pack(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            8'h55: g = glyph_pack(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            8'h56: g = glyph_pack(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            8'h57: g = glyph_pack(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
            8'h58: g = glyph_pack(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            8'h59: g = glyph_pack(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
            8'h5A: g = glyph_pack(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
            // '?' and every code not in the ROM
            default: g = glyph_pack(8'h02, 8'h01, 8'h51, 8'h09, 8'h06);
        endcase
        glyph_lookup = g;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/text_glyph_cell_renderer_unit.sv
// A character request goes to the lead-cell state on accept, and its cell is then
// registered into the output word. A number request runs through the shift-and-add-3 BCD
// converter, trims leading zeros, then draws a sign cell if signed and one cell per drawn digit.
// Requests are taken one at a time; a request on a hidden row is dropped on accept, and
// output stalls hold the sequencer in its cell states.
// Reset clears the sequencer and the output valid; there is no memory to clear.
// ============================================================================
// text_glyph_cell_renderer_unit
// Draws a character or a decimal number as 5x7 glyph cells, one result word
// per visible cell, with the framebuffer offset and five column bytes.
// ============================================================================
`default_nettype none

module text_glyph_cell_renderer_unit #(
    parameter int DISPLAY_WIDTH = 128,
    parameter int TEXT_ROWS     = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire tgcr_pkg::req_word_t req_word,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output tgcr_pkg::rsp_word_t     rsp_word
);
    import tgcr_pkg::*;

    localparam logic [7:0] CELLS_PER_ROW = 8'(DISPLAY_WIDTH / 6);
    localparam logic [7:0] ROW_LIMIT     = 8'(TEXT_ROWS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CONV  = 5'b00010,
        S_TRIM  = 5'b00100,
        S_LEAD  = 5'b01000,
        S_DIGIT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [BIN_BITS-1:0] bin_reg, bin_next;
    logic [BCD_BITS-1:0] bcd_reg, bcd_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [4:0]          ndig_reg, ndig_next;
    logic [7:0]          lead_col_reg, lead_col_next;
    logic [7:0]          dcol_reg, dcol_next;
    logic [7:0]          code_reg, code_next;
    logic                has_lead_reg, has_lead_next;
    logic                has_dig_reg, has_dig_next;
    logic [9:0]          row_off_reg, row_off_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_word_t           rsp_word_reg, rsp_word_next;

    logic                req_accept;
    logic                slot_free;
    logic                emit;
    logic [7:0]          em_code;
    logic [7:0]          em_col;
    logic                em_last;
    logic [BCD_BITS-1:0] bcd_adj;
    logic [BIN_BITS-1:0] mag;
    logic [9:0]          em_col10;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign slot_free  = !rsp_valid_reg || !rsp_stall;

    // Add-3 correction on every BCD digit before the shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Magnitude of a signed value
    assign mag = req_word.value[BIN_BITS-1] ? (~req_word.value + 64'd1) : req_word.value;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        cnt_next      = cnt_reg;
        ndig_next     = ndig_reg;
        lead_col_next = lead_col_reg;
        dcol_next     = dcol_reg;
        code_next     = code_reg;
        has_lead_next = has_lead_reg;
        has_dig_next  = has_dig_reg;
        row_off_next  = row_off_reg;
        emit          = 1'b0;
        em_code       = code_reg;
        em_col        = lead_col_reg;
        em_last       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    bcd_next      = '0;
                    cnt_next      = '0;
                    ndig_next     = 5'(DEC_DIGITS);
                    lead_col_next = req_word.column;
                    row_off_next  = 10'(18'(req_word.row) * 18'(DISPLAY_WIDTH));
                    if (req_word.row < ROW_LIMIT)
                    begin
                        unique case (action_t'(req_word.action))
                            ACT_CHAR:
                            begin
                                code_next     = req_word.character;
                                has_lead_next = 1'b1;
                                has_dig_next  = 1'b0;
                                state_next    = S_LEAD;
                            end
                            ACT_UNSIGNED:
                            begin
                                bin_next      = req_word.value;
                                dcol_next     = req_word.column;
                                has_lead_next = 1'b0;
                                has_dig_next  = 1'b1;
                                state_next    = S_CONV;
                            end
                            ACT_SIGNED:
                            begin
                                bin_next      = mag;
                                dcol_next     = req_word.column + 8'd1;
                                code_next     = req_word.value[BIN_BITS-1] ? CHAR_MINUS
                                                                           : CHAR_PLUS;
                                has_lead_next = 1'b1;
                                has_dig_next  = 1'b1;
                                state_next    = S_CONV;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end

            // One binary bit per cycle into the BCD register
            S_CONV:
            begin
                bcd_next = {bcd_adj[BCD_BITS-2:0], bin_reg[BIN_BITS-1]};
                bin_next = {bin_reg[BIN_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(BIN_BITS - 1))
                    state_next = S_TRIM;
            end

            // Drop leading zero digits, keeping at least one
            S_TRIM:
            begin
                if ((bcd_reg[BCD_BITS-1 -: 4] == 4'd0) && (ndig_reg > 5'd1))
                begin
                    bcd_next  = {bcd_reg[BCD_BITS-5:0], 4'd0};
                    ndig_next = ndig_reg - 5'd1;
                end
                else
                begin
                    state_next = has_lead_reg ? S_LEAD : S_DIGIT;
                end
            end

            // Character or sign cell
            S_LEAD:
            begin
                if (lead_col_reg >= CELLS_PER_ROW)
                begin
                    state_next = has_dig_reg ? S_DIGIT : S_IDLE;
                end
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    em_code    = code_reg;
                    em_col     = lead_col_reg;
                    em_last    = !(has_dig_reg && (dcol_reg < CELLS_PER_ROW));
                    state_next = has_dig_reg ? S_DIGIT : S_IDLE;
                end
            end

            // Digit cells, most significant first
            S_DIGIT:
            begin
                if (dcol_reg >= CELLS_PER_ROW)
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    emit      = 1'b1;
                    em_code   = CHAR_ZERO + {4'd0, bcd_reg[BCD_BITS-1 -: 4]};
                    em_col    = dcol_reg;
                    em_last   = (ndig_reg == 5'd1) || ((dcol_reg + 8'd1) >= CELLS_PER_ROW);
                    bcd_next  = {bcd_reg[BCD_BITS-5:0], 4'd0};
                    ndig_next = ndig_reg - 5'd1;
                    dcol_next = dcol_reg + 8'd1;
                    if (em_last)
                        state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    assign em_col10 = 10'(em_col);

    always_comb
    begin
        rsp_word_next = rsp_word_reg;
        if (emit)
        begin
            rsp_valid_next              = 1'b1;
            rsp_word_next.cell_offset   = row_off_reg + (em_col10 << 2) + (em_col10 << 1);
            rsp_word_next.glyph_columns = glyph_lookup(em_code);
            rsp_word_next.last          = em_last;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        ndig_reg     <= ndig_next;
        lead_col_reg <= lead_col_next;
        dcol_reg     <= dcol_next;
        code_reg     <= code_next;
        has_lead_reg <= has_lead_next;
        has_dig_reg  <= has_dig_next;
        row_off_reg  <= row_off_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

`default_nettype wire
